// ----- rtl/lscl_pkg.sv -----
// ----------------------------------------------------------------------------
// lscl_pkg
// Shared constants and types for the led strip current limiter.
// ----------------------------------------------------------------------------
package lscl_pkg;

	localparam int LSCL_MAX_PIXELS = 64;
	localparam int LSCL_CHAN_W     = 8;
	localparam int LSCL_PIX_W      = 4 * LSCL_CHAN_W;
	localparam int LSCL_SUM_W      = 16;
	localparam int LSCL_PROD_W     = LSCL_CHAN_W + LSCL_SUM_W;
	localparam logic [LSCL_SUM_W-1:0] LSCL_LIMIT_RESET = '1;

	// request from the frame sequencer to the serial scaler
	typedef struct packed {
		logic                   start;
		logic [LSCL_CHAN_W-1:0] value;
		logic [LSCL_SUM_W-1:0]  limit;
		logic [LSCL_SUM_W-1:0]  divisor;
	} lscl_scl_req_t;

	typedef enum logic [1:0] {
		SCL_IDLE,
		SCL_MUL,
		SCL_DIV,
		SCL_DONE
	} lscl_scl_state_t;

	typedef enum logic [3:0] {
		ST_COLLECT,
		ST_SC_RD,
		ST_SC_LOAD,
		ST_SC_START,
		ST_SC_RUN,
		ST_SC_WB,
		ST_EMIT_RD,
		ST_EMIT_LOAD,
		ST_EMIT_WAIT
	} lscl_state_t;

endpackage

// ----- rtl/lscl_pixel_mem.sv -----
// ----------------------------------------------------------------------------
// lscl_pixel_mem
// Frame pixel store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lscl_pixel_mem import lscl_pkg::*; #(
	parameter int DEPTH = LSCL_MAX_PIXELS,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [LSCL_PIX_W-1:0] wdata,
	input  logic [AW-1:0]         raddr,
	output logic [LSCL_PIX_W-1:0] rdata
);

	logic [LSCL_PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/lscl_scaler.sv -----
// ----------------------------------------------------------------------------
// lscl_scaler
// Bit-serial floor(value * limit / divisor): shift-add multiply, then
// restoring divide, one bit per cycle each. Inputs held during a run.
// ----------------------------------------------------------------------------
module lscl_scaler import lscl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lscl_scl_req_t          req,
	output logic                   done,
	output logic [LSCL_CHAN_W-1:0] quotient
);

	localparam int CNT_W = $clog2(LSCL_CHAN_W);

	lscl_scl_state_t state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [LSCL_CHAN_W-1:0] mcand_q;
	logic [LSCL_PROD_W-1:0] acc_q;
	logic [LSCL_SUM_W-1:0]  rem_q;
	logic [LSCL_CHAN_W-1:0] lo_q;
	logic [LSCL_CHAN_W-1:0] quo_q;

	logic [LSCL_PROD_W-1:0] acc_next;
	logic [LSCL_SUM_W:0]    trial;
	logic                   fits;
	logic                   last_step;

	assign acc_next  = {acc_q[LSCL_PROD_W-2:0], 1'b0}
		+ (mcand_q[LSCL_CHAN_W-1] ? LSCL_PROD_W'(req.limit) : '0);
	assign trial     = {rem_q, lo_q[LSCL_CHAN_W-1]};
	assign fits      = trial >= {1'b0, req.divisor};
	assign last_step = cnt_q == CNT_W'(LSCL_CHAN_W - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SCL_IDLE: if (req.start) state_d = SCL_MUL;
			SCL_MUL:  if (last_step) state_d = SCL_DIV;
			SCL_DIV:  if (last_step) state_d = SCL_DONE;
			SCL_DONE: state_d = SCL_IDLE;
			default:  state_d = SCL_IDLE;
		endcase
	end

	always_comb begin
		done     = state_q == SCL_DONE;
		quotient = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCL_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SCL_MUL || state_q == SCL_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SCL_IDLE: begin
				mcand_q <= req.value;
				acc_q   <= '0;
			end
			SCL_MUL: begin
				acc_q   <= acc_next;
				mcand_q <= {mcand_q[LSCL_CHAN_W-2:0], 1'b0};
				// quotient fits in 8 bits, so the high part starts below the divisor
				rem_q   <= acc_next[LSCL_PROD_W-1:LSCL_CHAN_W];
				lo_q    <= acc_next[LSCL_CHAN_W-1:0];
			end
			SCL_DIV: begin
				rem_q <= fits ? LSCL_SUM_W'(trial - {1'b0, req.divisor})
					: trial[LSCL_SUM_W-1:0];
				lo_q  <= {lo_q[LSCL_CHAN_W-2:0], 1'b0};
				quo_q <= {quo_q[LSCL_CHAN_W-2:0], fits};
			end
			SCL_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/led_strip_current_limiter.sv -----
// ----------------------------------------------------------------------------
// led_strip_current_limiter
// Frame store with channel-sum current estimate and proportional limiting.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle and stored until the frame ends (tlast or a
// full store). If the channel sum exceeds current_limit, every channel is
// rescaled to floor(v * limit / sum) by a bit-serial multiply/divide unit,
// one channel at a time, before output starts; an unlimited frame goes to
// output directly. Each output pixel is read from the store, loaded into a
// register and held until the downstream side accepts it. Input is not taken
// while a frame is being scaled or emitted. Each output carries the frame
// sum after limiting and a flag telling whether the frame was scaled.
module led_strip_current_limiter import lscl_pkg::*; #(
	parameter int MAX_PIXELS = LSCL_MAX_PIXELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [LSCL_SUM_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // white_in, red_in, green_in, blue_in
	input  logic                  s_tlast,   // frame_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,   // white_out, red_out, green_out,
	                                         // blue_out, frame_current
	output logic                  m_tuser,   // was_limited
	output logic                  m_tlast    // frame_last
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(MAX_PIXELS + 1);

	lscl_state_t state_q, state_d;

	logic [LSCL_SUM_W-1:0]  limit_q;
	logic [CW-1:0]          count_q;
	logic [LSCL_SUM_W-1:0]  sum_q;
	logic [LSCL_SUM_W-1:0]  div_q;
	logic [LSCL_SUM_W-1:0]  newsum_q;
	logic [LSCL_SUM_W-1:0]  frame_sum_q;
	logic                   limited_q;
	logic [AW-1:0]          idx_q;
	logic [AW-1:0]          last_idx_q;
	logic [1:0]             ch_q;
	logic [LSCL_PIX_W-1:0]  pixel_q;
	logic [LSCL_PIX_W-1:0]  out_pix_q;
	logic                   out_last_q;

	logic                   in_xfer;
	logic                   out_xfer;
	logic                   frame_done;
	logic [9:0]             pix_total;
	logic [LSCL_SUM_W-1:0]  sum_new;
	logic                   over;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [LSCL_PIX_W-1:0]  mem_wdata;
	logic [LSCL_PIX_W-1:0]  mem_rdata;

	lscl_scl_req_t          scl_req;
	logic                   scl_done;
	logic [LSCL_CHAN_W-1:0] scl_q;

	assign in_xfer    = s_tvalid && s_tready;
	assign out_xfer   = m_tvalid && m_tready;
	assign frame_done = s_tlast || count_q == CW'(MAX_PIXELS - 1);
	assign pix_total  = 10'(s_tdata[7:0]) + 10'(s_tdata[15:8])
		+ 10'(s_tdata[23:16]) + 10'(s_tdata[31:24]);
	assign sum_new    = sum_q + LSCL_SUM_W'(pix_total);
	assign over       = sum_new > limit_q;

	lscl_pixel_mem #(
		.DEPTH (MAX_PIXELS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	lscl_scaler u_scaler (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (scl_req),
		.done     (scl_done),
		.quotient (scl_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (in_xfer && frame_done) begin
					state_d = over ? ST_SC_RD : ST_EMIT_RD;
				end
			end
			ST_SC_RD:    state_d = ST_SC_LOAD;
			ST_SC_LOAD:  state_d = ST_SC_START;
			ST_SC_START: state_d = ST_SC_RUN;
			ST_SC_RUN: begin
				if (scl_done) begin
					state_d = (ch_q == 2'd3) ? ST_SC_WB : ST_SC_START;
				end
			end
			ST_SC_WB:     state_d = (idx_q == last_idx_q) ? ST_EMIT_RD : ST_SC_RD;
			ST_EMIT_RD:   state_d = ST_EMIT_LOAD;
			ST_EMIT_LOAD: state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: begin
				if (out_xfer) begin
					state_d = out_last_q ? ST_COLLECT : ST_EMIT_RD;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_comb begin
		s_tready        = state_q == ST_COLLECT;
		m_tvalid        = state_q == ST_EMIT_WAIT;
		m_tdata         = {frame_sum_q, out_pix_q};
		m_tuser         = limited_q;
		m_tlast         = out_last_q;
		mem_we          = in_xfer || state_q == ST_SC_WB;
		mem_waddr       = (state_q == ST_COLLECT) ? count_q[AW-1:0] : idx_q;
		mem_wdata       = (state_q == ST_COLLECT) ? s_tdata : pixel_q;
		scl_req.start   = state_q == ST_SC_START;
		scl_req.value   = pixel_q[LSCL_PIX_W-1 -: LSCL_CHAN_W];
		scl_req.limit   = limit_q;
		scl_req.divisor = div_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			limit_q     <= LSCL_LIMIT_RESET;
			count_q     <= '0;
			sum_q       <= '0;
			limited_q   <= 1'b0;
			idx_q       <= '0;
			ch_q        <= '0;
			out_last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (in_xfer) begin
						if (frame_done) begin
							count_q   <= '0;
							sum_q     <= '0;
							limited_q <= over;
							idx_q     <= '0;
						end else begin
							count_q <= count_q + 1'b1;
							sum_q   <= sum_new;
						end
					end
				end
				ST_SC_LOAD: ch_q <= '0;
				ST_SC_RUN: begin
					if (scl_done) begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_SC_WB: begin
					idx_q <= (idx_q == last_idx_q) ? '0 : idx_q + 1'b1;
				end
				ST_EMIT_LOAD: out_last_q <= idx_q == last_idx_q;
				ST_EMIT_WAIT: begin
					if (out_xfer && !out_last_q) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_COLLECT: begin
				if (in_xfer && frame_done) begin
					last_idx_q  <= count_q[AW-1:0];
					div_q       <= sum_new;
					frame_sum_q <= sum_new;
					newsum_q    <= '0;
				end
			end
			ST_SC_LOAD: pixel_q <= mem_rdata;
			ST_SC_RUN: begin
				if (scl_done) begin
					// rotate the scaled channel in, next channel comes to the top
					pixel_q  <= {pixel_q[LSCL_PIX_W-LSCL_CHAN_W-1:0], scl_q};
					newsum_q <= newsum_q + LSCL_SUM_W'(scl_q);
				end
			end
			ST_SC_WB: begin
				if (idx_q == last_idx_q) begin
					frame_sum_q <= newsum_q;
				end
			end
			ST_EMIT_LOAD: out_pix_q <= mem_rdata;
			default: begin
			end
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open at once");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(MAX_PIXELS))
		else $error("pixel count beyond store depth");

	a_scale_down: assert property (@(posedge clk) disable iff (!arst_n)
		scl_done |-> scl_q <= pixel_q[LSCL_PIX_W-1 -: LSCL_CHAN_W])
		else $error("scaled channel above its input");

endmodule

// ----- tb/led_strip_current_limiter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_current_limiter_test
// Self-checking bench for the led strip current limiter.
// ----------------------------------------------------------------------------
// Frames of pixels are streamed in under several current limits. A local
// model stores each frame, sums its channels and rescales it when the sum is
// above the limit, queueing the pixels the block should send back. Every
// output transaction is compared field by field with the oldest queued pixel.
// Both stream sides get random idle gaps and the output side random stalls.
module led_strip_current_limiter_test;
	import lscl_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_PIXELS  = 24;

	typedef struct packed {
		logic [7:0] white;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct {
		pixel_t          px;
		logic            last;
		logic            limited;
		logic [15:0]     current;
	} led_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // white_in, red_in, green_in, blue_in
	logic        s_tlast;   // frame_end
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // white_out, red_out, green_out, blue_out, frame_current
	logic        m_tuser;   // was_limited
	logic        m_tlast;   // frame_last

	// model state
	pixel_t      frame_px [LSCL_MAX_PIXELS];
	int unsigned frame_cnt;
	int unsigned frame_sum;
	int unsigned cur_limit;
	led_result_t led_out_q [$];

	int  errors;
	int  pixels_sent;
	int  frames_done;
	int  frames_limited;
	int  full_store_frames;
	int  results_checked;
	int  idle_cycles;
	bit  steady_flow;

	led_strip_current_limiter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_checked, name, got, want));
		end
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (steady_flow)
			return 0;
		if (sel < 50)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		if (sel < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		int     sel;
		sel = $urandom_range(0, 99);
		px = $urandom;
		if (sel < 15) begin
			px.white = 8'($urandom_range(0, 15));
			px.red   = 8'($urandom_range(0, 15));
			px.green = 8'($urandom_range(0, 15));
			px.blue  = 8'($urandom_range(0, 15));
		end else if (sel < 30) begin
			px.white = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return px;
	endfunction

	function automatic logic [7:0] scale_channel(input logic [7:0] v,
			input int unsigned lim, input int unsigned sum);
		longint unsigned prod;
		prod = longint'(v) * lim;
		return 8'(prod / sum);
	endfunction

	function automatic int unsigned pixel_weight(input pixel_t px);
		return px.white + px.red + px.green + px.blue;
	endfunction

	// store one pixel; on frame end queue the pixels the block must send
	task automatic store_pixel(input pixel_t px, input bit frame_end);
		led_result_t r;
		int unsigned total;
		int unsigned rescaled;
		bit          limited;
		pixel_t      p;
		frame_px[frame_cnt] = px;
		frame_cnt++;
		frame_sum += pixel_weight(px);
		if (frame_cnt >= LSCL_MAX_PIXELS) begin
			frame_end = 1'b1;
			full_store_frames++;
		end
		if (!frame_end)
			return;
		total = frame_sum;
		limited = total > cur_limit;
		if (limited) begin
			rescaled = 0;
			for (int i = 0; i < frame_cnt; i++) begin
				p = frame_px[i];
				p.white = scale_channel(p.white, cur_limit, total);
				p.red   = scale_channel(p.red, cur_limit, total);
				p.green = scale_channel(p.green, cur_limit, total);
				p.blue  = scale_channel(p.blue, cur_limit, total);
				frame_px[i] = p;
				rescaled += pixel_weight(p);
			end
			total = rescaled;
			frames_limited++;
		end
		for (int i = 0; i < frame_cnt; i++) begin
			r.px      = frame_px[i];
			r.last    = (i == frame_cnt - 1);
			r.limited = limited;
			r.current = 16'(total);
			led_out_q.push_back(r);
		end
		frames_done++;
		frame_cnt = 0;
		frame_sum = 0;
	endtask

	task automatic send_pixel(input pixel_t px, input bit frame_end);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			s_tlast  <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {px.blue, px.green, px.red, px.white};
		s_tlast  <= frame_end;
		do
			@(posedge clk);
		while (!s_tready);
		pixels_sent++;
		store_pixel(px, frame_end);
	endtask

	task automatic send_frame(input int len, input bit mark_last);
		for (int i = 0; i < len; i++)
			send_pixel(random_pixel(), mark_last && (i == len - 1));
	endtask

	task automatic input_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// register writes only once the block has emptied out
	task automatic write_limit(input logic [15:0] value);
		input_idle();
		wait (led_out_q.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_limit = value;
	endtask

	// output side stalls
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (n) @(negedge clk);
			n = pick_gap();
			if (n > 0)
				m_tready <= 1'b0;
			repeat (n) @(negedge clk);
		end
	end

	always @(posedge clk) begin : check_output
		led_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (led_out_q.size() == 0) begin
				report_mismatch("output transaction with no pixel expected");
			end else begin
				want = led_out_q.pop_front();
				check_field("white", m_tdata[7:0], want.px.white);
				check_field("red", m_tdata[15:8], want.px.red);
				check_field("green", m_tdata[23:16], want.px.green);
				check_field("blue", m_tdata[31:24], want.px.blue);
				check_field("frame_current", m_tdata[47:32], want.current);
				check_field("was_limited", m_tuser, want.limited);
				check_field("frame_last", m_tlast, want.last);
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// reset limit lets a full-white pixel and a dark one through untouched
	task automatic test_reset_limit();
		send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
		send_pixel('{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
	endtask

	task automatic test_channel_extremes();
		write_limit(16'hFFFF);
		send_pixel('{8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0);
		send_pixel('{8'h00, 8'hFF, 8'h00, 8'h00}, 1'b0);
		send_pixel('{8'h00, 8'h00, 8'hFF, 8'h00}, 1'b0);
		send_pixel('{8'h00, 8'h00, 8'h00, 8'hFF}, 1'b0);
		send_pixel('{8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0);
		send_pixel('{8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b1);
	endtask

	// zero limit: dark frame passes, lit frame goes fully dark
	task automatic test_zero_limit();
		write_limit(16'h0000);
		send_pixel('{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
		send_pixel('{8'h01, 8'h00, 8'h00, 8'h00}, 1'b0);
		send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
		send_pixel('{8'h80, 8'h40, 8'h20, 8'h10}, 1'b1);
	endtask

	// sum equal to the limit passes, one above gets scaled; then four full-white pixels are scaled under a limit of 1500
	task automatic test_limit_boundary();
		write_limit(16'd600);
		send_pixel('{8'd150, 8'd150, 8'd150, 8'd150}, 1'b1);
		send_pixel('{8'd150, 8'd150, 8'd150, 8'd151}, 1'b1);
		write_limit(16'd1500);
		for (int i = 0; i < 4; i++)
			send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF}, i == 3);
	endtask

	// store fills without frame end, then again with frame end on the last
	task automatic test_full_store();
		write_limit(16'd3000);
		send_frame(LSCL_MAX_PIXELS, 1'b0);
		write_limit(16'hFFFF);
		send_frame(LSCL_MAX_PIXELS, 1'b1);
	endtask

	task automatic test_random_frames();
		int start;
		int sel;
		int len;
		int frames_left;
		int remaining;
		start = pixels_sent;
		frames_left = 0;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			if (frames_left == 0) begin
				sel = $urandom_range(0, 99);
				if (sel < 10)
					write_limit(16'h0000);
				else if (sel < 20)
					write_limit(16'hFFFF);
				else if (sel < 25)
					write_limit(16'h0001);
				else if (sel < 65)
					write_limit(16'($urandom_range(0, 3000)));
				else
					write_limit(16'($urandom));
				frames_left = $urandom_range(1, 4);
				steady_flow = ($urandom_range(0, 4) == 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 55)
				len = $urandom_range(1, 4);
			else if (sel < 90)
				len = $urandom_range(5, 16);
			else if (sel < 96)
				len = $urandom_range(17, 40);
			else
				len = LSCL_MAX_PIXELS;
			remaining = RANDOM_PIXELS - (pixels_sent - start);
			if (len > remaining)
				len = remaining;
			send_frame(len, (len < LSCL_MAX_PIXELS) || $urandom_range(0, 1));
			frames_left--;
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		frame_cnt   = 0;
		frame_sum   = 0;
		cur_limit   = LSCL_LIMIT_RESET;
		errors      = 0;
		idle_cycles = 0;
		steady_flow = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_limit();
		test_channel_extremes();
		test_zero_limit();
		test_limit_boundary();
		test_full_store();
		test_random_frames();

		input_idle();
		wait (led_out_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pixels in %0d frames, %0d scaled down, %0d ended by full store",
			pixels_sent, frames_done, frames_limited, full_store_frames);
		$display("checked %0d output pixels, %0d mismatches", results_checked, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
